### sv/assert_macros.svh
// Assertion macros shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define EXL_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Common form: the house clock and reset names.
`define EXL_ASSERT(lbl, prop, msg) \
  `EXL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### sv/exl_pkg.sv
// Types and constants shared by the expression lexer modules.
package exl_pkg;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeNumber = 2'd1,
    ModeId     = 2'd2,
    ModeString = 2'd3
  } lex_mode_e;

  typedef enum logic [2:0] {
    TokComma    = 3'd0,
    TokOpen     = 3'd1,
    TokClose    = 3'd2,
    TokOperator = 3'd3,
    TokNumber   = 3'd4,
    TokId       = 3'd5,
    TokString   = 3'd6,
    TokEnd      = 3'd7
  } tok_type_e;

  localparam int unsigned OutBits  = 16;
  localparam int unsigned RunSlots = 3;

  typedef struct packed {
    tok_type_e          kind;
    logic [OutBits-1:0] start;
    logic [OutBits-1:0] length;
    logic [7:0]         first;
  } token_t;

  // Tokens produced by one character, oldest in slot 0.
  typedef struct packed {
    token_t [RunSlots-1:0] tok;
    logic   [1:0]          cnt;
  } run_t;

endpackage

### sv/exl_if.sv
// Valid/ready channel interfaces for characters in and tokens out.
interface exl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, ch, last_char, input ready);
  modport sink   (input valid, ch, last_char, output ready);
endinterface

interface exl_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 token_type;
  logic [exl_pkg::OutBits-1:0] token_start;
  logic [exl_pkg::OutBits-1:0] token_length;
  logic [7:0]                 first_char;
  logic                       last_of_run;

  modport source (output valid, token_type, token_start, token_length, first_char,
                  last_of_run, input ready);
  modport sink   (input valid, token_type, token_start, token_length, first_char,
                  last_of_run, output ready);
endinterface

### sv/exl_lexer.sv
// Lexer state and per-character token classification.
`include "assert_macros.svh"

module exl_lexer #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  output exl_pkg::run_t    run_o
);

  localparam logic [POS_BITS-1:0] PosMax = '1;
  localparam int unsigned ExtW = (POS_BITS > exl_pkg::OutBits) ? POS_BITS : exl_pkg::OutBits;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  exl_pkg::lex_mode_e  mode_q, mode_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [7:0]          first_q, first_d;
  logic [POS_BITS-1:0] pos_q, pos_d;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [exl_pkg::OutBits-1:0] sat_out(input logic [POS_BITS-1:0] v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return (e > ExtW'({exl_pkg::OutBits{1'b1}})) ? {exl_pkg::OutBits{1'b1}}
                                                 : e[exl_pkg::OutBits-1:0];
  endfunction

  function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] from,
                                               input logic [POS_BITS-1:0] upto);
    return (upto > from) ? upto - from : '0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNul);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == ChPlus) || (c == ChMinus) || (c == ChStar) || (c == ChSlash) ||
           (c == ChCaret) || (c == ChPct);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic exl_pkg::tok_type_e mode_tok(input exl_pkg::lex_mode_e m);
    exl_pkg::tok_type_e t;
    unique case (m)
      exl_pkg::ModeNumber: t = exl_pkg::TokNumber;
      exl_pkg::ModeId:     t = exl_pkg::TokId;
      default:             t = exl_pkg::TokString;
    endcase
    return t;
  endfunction

  function automatic exl_pkg::token_t mk_tok(input exl_pkg::tok_type_e k,
                                             input logic [POS_BITS-1:0] s,
                                             input logic [POS_BITS-1:0] len,
                                             input logic [7:0] f);
    exl_pkg::token_t t;
    t.kind   = k;
    t.start  = sat_out(s);
    t.length = sat_out(len);
    t.first  = f;
    return t;
  endfunction

  exl_pkg::token_t [3:0] cand;
  logic [3:0]            cand_v;
  logic [POS_BITS-1:0]   end_pos;
  logic                  sep;
  logic                  fresh;
  logic [7:0]            id_first;
  logic [2:0]            k;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    first_d  = first_q;
    fresh    = 1'b1;
    cand     = '0;
    cand_v   = '0;
    end_pos  = sat_inc(pos_q);
    sep      = (ch_i == ChComma) || (ch_i == ChOpen) || (ch_i == ChClose) ||
               is_op(ch_i) || is_blank(ch_i);
    id_first = (pos_q == start_q) ? ch_i : first_q;

    // Close the open token if this character ends it.
    unique case (mode_q)
      exl_pkg::ModeNumber: begin
        if (is_digit(ch_i) || (ch_i == ChDot)) begin
          fresh = 1'b0;
        end else begin
          cand[0]   = mk_tok(exl_pkg::TokNumber, start_q, span(start_q, pos_q), first_q);
          cand_v[0] = 1'b1;
          mode_d    = exl_pkg::ModeIdle;
        end
      end
      exl_pkg::ModeString: begin
        if (sep) begin
          cand[0]   = mk_tok(exl_pkg::TokString, start_q, span(start_q, pos_q), first_q);
          cand_v[0] = 1'b1;
          mode_d    = exl_pkg::ModeIdle;
        end else begin
          fresh = 1'b0;
        end
      end
      exl_pkg::ModeId: begin
        fresh   = 1'b0;
        first_d = id_first;
        if ((ch_i == ChQuote) || (ch_i == ChNul)) begin
          cand[0]   = mk_tok(exl_pkg::TokId, start_q, span(start_q, pos_q), id_first);
          cand_v[0] = 1'b1;
          mode_d    = exl_pkg::ModeIdle;
        end
      end
      default: ;
    endcase

    // The character starts something new.
    if (fresh && !is_blank(ch_i)) begin
      if (ch_i == ChComma) begin
        cand[1]   = mk_tok(exl_pkg::TokComma, pos_q, POS_BITS'(1), ch_i);
        cand_v[1] = 1'b1;
      end else if (ch_i == ChOpen) begin
        cand[1]   = mk_tok(exl_pkg::TokOpen, pos_q, POS_BITS'(1), ch_i);
        cand_v[1] = 1'b1;
      end else if (ch_i == ChClose) begin
        cand[1]   = mk_tok(exl_pkg::TokClose, pos_q, POS_BITS'(1), ch_i);
        cand_v[1] = 1'b1;
      end else if (is_op(ch_i)) begin
        cand[1]   = mk_tok(exl_pkg::TokOperator, pos_q, POS_BITS'(1), ch_i);
        cand_v[1] = 1'b1;
      end else if (is_digit(ch_i)) begin
        mode_d  = exl_pkg::ModeNumber;
        start_d = pos_q;
        first_d = ch_i;
      end else if (ch_i == ChQuote) begin
        mode_d  = exl_pkg::ModeId;
        start_d = sat_inc(pos_q);
        first_d = 8'h00;
      end else begin
        mode_d  = exl_pkg::ModeString;
        start_d = pos_q;
        first_d = ch_i;
      end
    end

    // End of text closes what is open, adds the end marker and rewinds.
    if (last_i) begin
      if (mode_d != exl_pkg::ModeIdle) begin
        cand[2]   = mk_tok(mode_tok(mode_d), start_d, span(start_d, end_pos), first_d);
        cand_v[2] = 1'b1;
      end
      cand[3]   = mk_tok(exl_pkg::TokEnd, end_pos, '0, 8'h00);
      cand_v[3] = 1'b1;
      mode_d    = exl_pkg::ModeIdle;
      start_d   = '0;
      first_d   = 8'h00;
      pos_d     = '0;
    end else begin
      pos_d = end_pos;
    end

    // Pack the valid candidates into the run slots in order.
    run_o = '0;
    k     = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (k < 3'(exl_pkg::RunSlots)) begin
          run_o.tok[k[1:0]] = cand[i];
        end
        k = k + 3'd1;
      end
    end
    run_o.cnt = k[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= exl_pkg::ModeIdle;
      start_q <= '0;
      first_q <= 8'h00;
      pos_q   <= '0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      first_q <= first_d;
      pos_q   <= pos_d;
    end
  end

  `EXL_ASSERT(a_rewind_after_last,
              take_i && last_i |=> (mode_q == exl_pkg::ModeIdle) && (pos_q == '0),
              "lexer did not rewind after the last character")
  `EXL_ASSERT(a_last_gives_end,
              take_i && last_i |-> (run_o.cnt != 2'd0) &&
              (run_o.tok[run_o.cnt - 2'd1].kind == exl_pkg::TokEnd),
              "last character did not finish with an end marker")

endmodule

### sv/exl_run_buf.sv
// Result buffer: holds the tokens of one character and hands them out one a cycle while ready_i is high.
`include "assert_macros.svh"

module exl_run_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  exl_pkg::run_t   run_i,
  output logic            load_ready_o,
  output logic            valid_o,
  input  logic            ready_i,
  output exl_pkg::token_t tok_o,
  output logic            last_o
);

  exl_pkg::token_t [exl_pkg::RunSlots-1:0] slot_q;
  logic [1:0]                              cnt_q;
  logic                                    pop;

  assign valid_o      = (cnt_q != 2'd0);
  assign pop          = valid_o && ready_i;
  assign load_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);
  assign tok_o        = slot_q[0];
  assign last_o       = (cnt_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= run_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= run_i.tok;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  `EXL_ASSERT(a_no_load_over_run, cnt_q >= 2'd2 |-> !load_ready_o,
              "buffer accepts a character while tokens are pending")
  `EXL_ASSERT(a_load_shows, load_i && (run_i.cnt != 2'd0) |=> valid_o,
              "loaded tokens not presented")
  `EXL_ASSERT(a_wait_holds, valid_o && !ready_i |=> valid_o && $stable(cnt_q),
              "pending tokens lost while stalled")

endmodule

### sv/expression_lexer_core.sv
// Top level of the streaming arithmetic expression lexer.
//
//  Channel | Dir | Handshake     | Payload
//  --------+-----+---------------+-----------------------------------------------
//  in_i    | in  | valid / ready | ch[7:0], last_char
//  out_o   | out | valid / ready | token_type[2:0], token_start[15:0],
//          |     |               | token_length[15:0], first_char[7:0], last_of_run
//
// A character is classified in the cycle it is accepted; its tokens (none to
// three) appear on out_o from the next cycle, one token per cycle while out_o is ready.
// One-token characters can follow every cycle while out_o is ready; a two- or
// three-token character holds off the next request while the buffer drains.
// rst_ni clears the lexer state and empties the result buffer at once. While
// out_o stalls, the tokens stay put and in_i waits unless the buffer empties now.

module expression_lexer_core #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  exl_in_if.sink      in_i,
  exl_out_if.source   out_o
);

  exl_pkg::run_t   run;
  exl_pkg::token_t tok;
  logic            take;
  logic            buf_ready;

  // A request is taken whenever the result buffer can absorb its tokens.
  assign in_i.ready = buf_ready;
  assign take       = in_i.valid && buf_ready;

  // Character classification and the open-token state.
  exl_lexer #(
    .POS_BITS (POS_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (in_i.ch),
    .last_i (in_i.last_char),
    .run_o  (run)
  );

  // Registered tokens of the most recent character, drained in order.
  exl_run_buf u_run_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take),
    .run_i        (run),
    .load_ready_o (buf_ready),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .tok_o        (tok),
    .last_o       (out_o.last_of_run)
  );

  assign out_o.token_type   = tok.kind;
  assign out_o.token_start  = tok.start;
  assign out_o.token_length = tok.length;
  assign out_o.first_char   = tok.first;

endmodule
